// ===== sv/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

  localparam int NUM_PAGES   = 4096;
  localparam int MAX_ORDER   = 10;
  localparam int PAGE_W      = 12;
  localparam int COUNT_W     = 13;
  localparam int POS_W       = 13;
  localparam int ORDER_W     = 4;
  localparam int WORD_W      = 64;
  localparam int WADDR_W     = 7;
  localparam int BIT_W       = 6;
  localparam int MAP_WORDS   = 128;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MEM    = 3'd1;
  localparam logic [2:0] ST_BAD_ORDER = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_PICK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 clr;
    logic                 re;
    logic [WADDR_W-1:0]   raddr;
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_W-1:0]    wdata;
  } map_req_t;

  function automatic logic [POS_W-1:0] map_base(input logic [ORDER_W-1:0] o);
    logic [POS_W:0] full;
    full = (POS_W+1)'(2 * NUM_PAGES);
    return POS_W'(full - (full >> o));
  endfunction

  function automatic logic [POS_W-1:0] map_pos(input logic [ORDER_W-1:0] o,
                                               input logic [PAGE_W-1:0] page);
    return map_base(o) + POS_W'(page >> o);
  endfunction

  function automatic logic [ORDER_W-1:0] order_of_pos(input logic [POS_W-1:0] p);
    logic [ORDER_W-1:0] res;
    res = '0;
    for (int o = 0; o <= MAX_ORDER; o++) begin
      if (p >= map_base(ORDER_W'(o))) res = ORDER_W'(o);
    end
    return res;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) res = BIT_W'(i);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bpa_map_store.sv =====
`default_nettype none
module bpa_map_store (
  input  wire                                clk,
  input  wire                                rst_n,
  input  bpa_pkg::map_req_t                  req,
  output logic [bpa_pkg::WORD_W-1:0]         rdata
);
  import bpa_pkg::*;

  logic [WORD_W-1:0]    mem_r [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_r;
  logic [WORD_W-1:0]    data_r;
  logic                 hit_r;

  always_ff @(posedge clk) begin
    if (req.we) mem_r[req.waddr] <= req.wdata;
    if (req.re) data_r <= mem_r[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      if (req.re) hit_r <= valid_r[req.raddr];
    end
  end

  assign rdata = hit_r ? data_r : '0;

endmodule
`default_nettype wire

// ===== sv/buddy_page_allocator_core.sv =====
`default_nettype none
// Buddy page allocator over 4096 pages, block orders 0 to 10.
// Request channel: pulse start with in_action (0 init, 1 alloc, 2 free),
// in_order and in_page_index while busy is low; the request is taken at
// that edge and busy stays high until the result is shown.
// Result channel: out_valid is high for exactly one cycle with out_status,
// out_page_index_res and out_free_cnt; the receiver cannot stall it.
// Configuration: cfg_we with cfg_index 0 (region first page) or 1 (region
// end page), written by the user only while busy is low (not checked).
// Flow: the free maps live in one 128 x 64 bit memory with a read port
// and a write port; every map update is a read-modify-write. Alloc scans
// map words from the requested order's base to the first set bit, then
// splits one order at a time; free reads each buddy and merges while it
// is free, then marks the final block; init seeds the largest aligned
// block that fits at each step. Errors go straight to the result.
// One request is worked on at a time.
// Reset: synchronous, active low; all maps read as empty, free count zero,
// region 0 to 4096. Init clears the maps at once through per-word valid bits.
module buddy_page_allocator_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [1:0]                     in_action,
  input  wire  [3:0]                     in_order,
  input  wire  [11:0]                    in_page_index,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [11:0]                    out_page_index_res,
  output logic [12:0]                    out_free_cnt,
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire  [12:0]                    cfg_wdata
);
  import bpa_pkg::*;

  state_t               state_r, state_nxt;
  logic [1:0]           act_r, act_nxt;
  logic [ORDER_W-1:0]   ord_r, ord_nxt;
  logic [ORDER_W-1:0]   o_r, o_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [COUNT_W-1:0]   addr_r, addr_nxt;
  logic [POS_W-1:0]     tgt_r, tgt_nxt;
  logic                 setv_r, setv_nxt;
  logic                 fin_r, fin_nxt;
  logic [WADDR_W-1:0]   w_r, w_nxt;
  logic [BIT_W-1:0]     lo_r, lo_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [PAGE_W-1:0]    res_r, res_nxt;
  logic [PAGE_W-1:0]    first_r;
  logic [COUNT_W-1:0]   end_r;

  map_req_t             req;
  logic [WORD_W-1:0]    rdata;

  logic [COUNT_W-1:0]   end_c;
  logic [COUNT_W:0]     sum_w;
  logic [COUNT_W-1:0]   sz_w;
  logic [WORD_W-1:0]    word_w;
  logic [POS_W-1:0]     p_w;
  logic [ORDER_W-1:0]   of_w;
  logic [PAGE_W-1:0]    buddy_w;
  logic [PAGE_W-1:0]    sub_w;
  logic [ORDER_W-1:0]   pick_w;
  logic [POS_W-1:0]     base_w;
  logic [POS_W-1:0]     fpos_w;

  bpa_map_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      end_r   <= COUNT_W'(NUM_PAGES);
    end else if (cfg_we) begin
      if (cfg_index) end_r <= cfg_wdata;
      else           first_r <= cfg_wdata[PAGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    ord_r    <= ord_nxt;
    o_r      <= o_nxt;
    page_r   <= page_nxt;
    addr_r   <= addr_nxt;
    tgt_r    <= tgt_nxt;
    setv_r   <= setv_nxt;
    fin_r    <= fin_nxt;
    w_r      <= w_nxt;
    lo_r     <= lo_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign end_c = (end_r > COUNT_W'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES) : end_r;

  always_comb begin
    pick_w = '0;
    for (int o = 1; o <= MAX_ORDER; o++) begin
      if ((({1'b0, addr_r} + ((COUNT_W+1)'(1) << o)) <= {1'b0, end_c}) &&
          ((addr_r & ((COUNT_W'(1) << o) - COUNT_W'(1))) == '0))
        pick_w = ORDER_W'(o);
    end
  end

  assign word_w  = rdata & ({WORD_W{1'b1}} << lo_r);
  assign p_w     = {w_r, lowest_set(word_w)};
  assign of_w    = order_of_pos(p_w);
  assign buddy_w = page_r ^ (PAGE_W'(1) << o_r);
  assign base_w  = map_base(in_order);
  assign fpos_w  = map_pos(o_r, buddy_w);

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    ord_nxt    = ord_r;
    o_nxt      = o_r;
    page_nxt   = page_r;
    addr_nxt   = addr_r;
    tgt_nxt    = tgt_r;
    setv_nxt   = setv_r;
    fin_nxt    = fin_r;
    w_nxt      = w_r;
    lo_nxt     = lo_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    req        = '0;
    sum_w      = '0;
    sz_w       = '0;
    sub_w      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt    = in_action;
          ord_nxt    = in_order;
          page_nxt   = in_page_index;
          status_nxt = ST_OK;
          res_nxt    = '0;
          fin_nxt    = 1'b0;
          state_nxt  = S_DONE;
          case (in_action)
            ACT_INIT: begin
              req.clr = 1'b1;
              cnt_nxt = '0;
              if (end_c <= COUNT_W'(first_r)) begin
                status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = COUNT_W'(first_r);
                state_nxt = S_INIT_PICK;
              end
            end
            ACT_ALLOC: begin
              if (in_order > ORDER_W'(MAX_ORDER)) begin
                status_nxt = ST_BAD_ORDER;
              end else begin
                w_nxt     = base_w[POS_W-1:BIT_W];
                lo_nxt    = base_w[BIT_W-1:0];
                state_nxt = S_SCAN_RD;
              end
            end
            ACT_FREE: begin
              sz_w  = COUNT_W'(1) << in_order;
              sum_w = (COUNT_W+1)'(in_page_index) + (COUNT_W+1)'(sz_w);
              if (in_order > ORDER_W'(MAX_ORDER)) begin
                status_nxt = ST_BAD_ORDER;
              end else if (((COUNT_W'(in_page_index) & (sz_w - COUNT_W'(1))) != '0) ||
                           (in_page_index < first_r) || (sum_w > {1'b0, end_c})) begin
                status_nxt = ST_BAD_PAGE;
              end else begin
                sum_w   = {1'b0, cnt_r} + (COUNT_W+1)'(sz_w);
                cnt_nxt = (sum_w > (COUNT_W+1)'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES)
                                                            : sum_w[COUNT_W-1:0];
                o_nxt   = in_order;
                if (in_order < ORDER_W'(MAX_ORDER)) begin
                  state_nxt = S_FREE_RD;
                end else begin
                  tgt_nxt   = map_pos(in_order, in_page_index);
                  setv_nxt  = 1'b1;
                  fin_nxt   = 1'b1;
                  state_nxt = S_RMW_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_INIT_PICK: begin
        tgt_nxt   = map_pos(pick_w, addr_r[PAGE_W-1:0]);
        setv_nxt  = 1'b1;
        cnt_nxt   = cnt_r + (COUNT_W'(1) << pick_w);
        addr_nxt  = addr_r + (COUNT_W'(1) << pick_w);
        state_nxt = S_RMW_RD;
      end

      S_SCAN_RD: begin
        req.re    = 1'b1;
        req.raddr = w_r;
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        lo_nxt = '0;
        if (word_w != '0) begin
          o_nxt     = of_w;
          page_nxt  = PAGE_W'((p_w - map_base(of_w)) << of_w);
          tgt_nxt   = p_w;
          setv_nxt  = 1'b0;
          state_nxt = S_RMW_WR;
        end else if (w_r == WADDR_W'(MAP_WORDS - 1)) begin
          status_nxt = ST_NO_MEM;
          state_nxt  = S_DONE;
        end else begin
          w_nxt     = w_r + WADDR_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_FREE_RD: begin
        tgt_nxt   = fpos_w;
        req.re    = 1'b1;
        req.raddr = fpos_w[POS_W-1:BIT_W];
        state_nxt = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (rdata[tgt_r[BIT_W-1:0]]) begin
          setv_nxt  = 1'b0;
          state_nxt = S_RMW_WR;
        end else begin
          tgt_nxt   = map_pos(o_r, page_r);
          setv_nxt  = 1'b1;
          fin_nxt   = 1'b1;
          state_nxt = S_RMW_RD;
        end
      end

      S_RMW_RD: begin
        req.re    = 1'b1;
        req.raddr = tgt_r[POS_W-1:BIT_W];
        state_nxt = S_RMW_WR;
      end

      S_RMW_WR: begin
        req.we    = 1'b1;
        req.waddr = tgt_r[POS_W-1:BIT_W];
        req.wdata = rdata;
        req.wdata[tgt_r[BIT_W-1:0]] = setv_r;
        state_nxt = S_DONE;
        case (act_r)
          ACT_INIT: begin
            if (addr_r < end_c) state_nxt = S_INIT_PICK;
          end
          ACT_ALLOC: begin
            if (o_r > ord_r) begin
              o_nxt     = o_r - ORDER_W'(1);
              sub_w     = page_r + (PAGE_W'(1) << (o_r - ORDER_W'(1)));
              tgt_nxt   = map_pos(o_r - ORDER_W'(1), sub_w);
              setv_nxt  = 1'b1;
              state_nxt = S_RMW_RD;
            end else begin
              sz_w    = COUNT_W'(1) << ord_r;
              cnt_nxt = cnt_r - ((sz_w > cnt_r) ? cnt_r : sz_w);
              res_nxt = page_r;
            end
          end
          ACT_FREE: begin
            if (!fin_r) begin
              page_nxt = page_r & ~(PAGE_W'(1) << o_r);
              o_nxt    = o_r + ORDER_W'(1);
              if (o_r + ORDER_W'(1) < ORDER_W'(MAX_ORDER)) begin
                state_nxt = S_FREE_RD;
              end else begin
                tgt_nxt   = map_pos(o_r + ORDER_W'(1), page_r & ~(PAGE_W'(1) << o_r));
                setv_nxt  = 1'b1;
                fin_nxt   = 1'b1;
                state_nxt = S_RMW_RD;
              end
            end
          end
          default: ;
        endcase
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_status         = status_r;
  assign out_page_index_res = res_r;
  assign out_free_cnt       = cnt_r;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bpa_pkg::*;

  localparam bit REG_FIRST = 1'b0;
  localparam bit REG_END   = 1'b1;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] page;
    logic [12:0] free;
  } alloc_result_t;

  typedef struct {
    logic [11:0] page;
    logic [3:0]  order;
  } block_t;

  class alloc_scoreboard;
    bit [4095:0]   free_bits [0:MAX_ORDER];
    int            free_cnt;
    int            first_pg;
    int            end_pg;
    alloc_result_t pending_q[$];
    int            errors;

    function new();
      foreach (free_bits[k]) free_bits[k] = '0;
      free_cnt = 0;
      first_pg = 0;
      end_pg   = NUM_PAGES;
      errors   = 0;
    endfunction

    function void set_reg(bit idx, logic [12:0] val);
      if (idx == REG_FIRST) first_pg = int'(val[11:0]);
      else end_pg = int'(val);
    endfunction

    function logic [2:0] note(logic [1:0] act, logic [3:0] ord_in, logic [11:0] pg_in,
                              output logic [11:0] got_page);
      alloc_result_t r;
      int lim, o, ord, idx, p, sz, a, b, n;
      bit found;
      r.status = ST_OK;
      r.page = '0;
      ord = int'(ord_in);
      lim = (end_pg > NUM_PAGES) ? NUM_PAGES : end_pg;
      case (act)
        ACT_INIT: begin
          foreach (free_bits[k]) free_bits[k] = '0;
          free_cnt = 0;
          if (lim <= first_pg) begin
            r.status = ST_EMPTY;
          end else begin
            a = first_pg;
            while (a < lim) begin
              o = MAX_ORDER;
              while (o > 0 && ((a + (1 << o) > lim) || (a % (1 << o)) != 0)) o--;
              free_bits[o][a >> o] = 1'b1;
              free_cnt += 1 << o;
              a += 1 << o;
            end
          end
        end
        ACT_ALLOC: begin
          if (ord > MAX_ORDER) begin
            r.status = ST_BAD_ORDER;
          end else begin
            found = 0;
            p = 0;
            for (o = ord; o <= MAX_ORDER && !found; o++) begin
              n = NUM_PAGES >> o;
              for (idx = 0; idx < n; idx++) begin
                if (free_bits[o][idx]) begin
                  p = idx << o;
                  found = 1;
                  break;
                end
              end
            end
            if (!found) begin
              r.status = ST_NO_MEM;
            end else begin
              o--;
              free_bits[o][p >> o] = 1'b0;
              while (o > ord) begin
                o--;
                free_bits[o][(p + (1 << o)) >> o] = 1'b1;
              end
              sz = 1 << ord;
              free_cnt -= (sz > free_cnt) ? free_cnt : sz;
              r.page = p[11:0];
            end
          end
        end
        ACT_FREE: begin
          p = int'(pg_in);
          if (ord > MAX_ORDER) begin
            r.status = ST_BAD_ORDER;
          end else if ((p % (1 << ord)) != 0 || p < first_pg || p + (1 << ord) > lim) begin
            r.status = ST_BAD_PAGE;
          end else begin
            sz = 1 << ord;
            free_cnt = (free_cnt + sz > NUM_PAGES) ? NUM_PAGES : free_cnt + sz;
            o = ord;
            while (o < MAX_ORDER) begin
              b = p ^ (1 << o);
              if (!free_bits[o][b >> o]) break;
              free_bits[o][b >> o] = 1'b0;
              p &= ~(1 << o);
              o++;
            end
            free_bits[o][p >> o] = 1'b1;
          end
        end
        default: ;
      endcase
      r.free = free_cnt[12:0];
      got_page = r.page;
      pending_q.push_back(r);
      return r.status;
    endfunction

    function void check(logic [2:0] status, logic [11:0] page, logic [12:0] free);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request pending: status %0d page %0d free %0d",
               status, page, free);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (page !== e.page) begin
        $error("page_index_res: expected %0d, actual %0d", e.page, page);
        errors++;
      end
      if (free !== e.free) begin
        $error("free_cnt: expected %0d, actual %0d", e.free, free);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [3:0]  in_order;
  logic [11:0] in_page_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [11:0] out_page_index_res;
  logic [12:0] out_free_cnt;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_wdata;

  alloc_scoreboard sb;
  block_t          live_q[$];
  int              stall_cnt;

  buddy_page_allocator_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_order          (in_order),
    .in_page_index     (in_page_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_page_index_res(out_page_index_res),
    .out_free_cnt      (out_free_cnt),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_status, out_page_index_res, out_free_cnt);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_request(logic [1:0] act, logic [3:0] ord, logic [11:0] pg);
    int gap;
    logic [11:0] got;
    logic [2:0] st;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    in_action = act;
    in_order = ord;
    in_page_index = pg;
    start = 1'b1;
    do @(posedge clk); while (busy);
    st = sb.note(act, ord, pg, got);
    if (act == ACT_INIT) live_q.delete();
    if (act == ACT_ALLOC && st == ST_OK) live_q.push_back('{got, ord});
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [12:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_region(logic [12:0] first, logic [12:0] last);
    drain();
    write_reg(REG_FIRST, first);
    write_reg(REG_END, last);
  endtask

  task automatic random_phase(int n);
    int sel, k;
    block_t blk;
    logic [3:0] ord;
    send_request(ACT_INIT, 4'($urandom), 12'($urandom));
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40 || (sel < 80 && live_q.size() == 0)) begin
        k = $urandom_range(0, 19);
        ord = (k < 12) ? 4'($urandom_range(0, 3)) :
              (k < 18) ? 4'($urandom_range(4, 10)) : 4'($urandom_range(11, 15));
        send_request(ACT_ALLOC, ord, 12'($urandom));
      end else if (sel < 80) begin
        k = $urandom_range(0, live_q.size() - 1);
        blk = live_q[k];
        live_q.delete(k);
        send_request(ACT_FREE, blk.order, blk.page);
      end else if (sel < 88) begin
        send_request(ACT_FREE, 4'($urandom_range(0, 15)), 12'($urandom));
      end else if (sel < 93 && live_q.size() != 0) begin
        blk = live_q[$urandom_range(0, live_q.size() - 1)];
        send_request(ACT_FREE, blk.order, blk.page);
      end else if (sel < 97) begin
        send_request(ACT_INIT, 4'($urandom), 12'($urandom));
      end else begin
        send_request(ACT_NOP, 4'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_INIT;
    in_order = '0;
    in_page_index = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FIRST;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(ACT_ALLOC, 4'd0, 12'd0);
    set_region(13'd0, 13'd4);
    send_request(ACT_INIT, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd2, 12'd0);
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    send_request(ACT_FREE, 4'd2, 12'd0);
    send_request(ACT_FREE, 4'd11, 12'd0);
    send_request(ACT_FREE, 4'd1, 12'd1);
    send_request(ACT_FREE, 4'd0, 12'd4);
    send_request(ACT_FREE, 4'd0, 12'd0);
    send_request(ACT_FREE, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd15, 12'd0);
    send_request(ACT_ALLOC, 4'd11, 12'd0);
    send_request(ACT_NOP, 4'd15, 12'hFFF);
    send_request(ACT_ALLOC, 4'd10, 12'd0);
    set_region(13'd4095, 13'd8191);
    send_request(ACT_INIT, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    send_request(ACT_FREE, 4'd0, 12'd4095);
    set_region(13'd100, 13'd50);
    send_request(ACT_INIT, 4'd0, 12'd0);
    set_region(13'd0, 13'd4096);
    send_request(ACT_INIT, 4'd0, 12'd0);
    send_request(ACT_ALLOC, 4'd10, 12'd0);
    send_request(ACT_ALLOC, 4'd0, 12'd0);
    send_request(ACT_FREE, 4'd10, 12'd0);
    send_request(ACT_FREE, 4'd0, 12'd1024);

    random_phase(150);
    set_region(13'd0, 13'd8191);
    random_phase(90);
    set_region(13'd4095, 13'd4096);
    random_phase(20);
    set_region(13'd1000, 13'd1100);
    random_phase(60);
    set_region(13'd37, 13'd3001);
    random_phase(120);
    for (int i = 0; i < 3; i++) begin
      set_region(13'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
      random_phase(30);
    end

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== buddy_page_allocator_core.f =====
sv/bpa_pkg.sv
sv/bpa_map_store.sv
sv/buddy_page_allocator_core.sv
bench/tb.sv
